### rtl/mbsoil_pkg.sv
// Shared types, codes and the CRC-16 byte step for the soil sensor Modbus master.
// Used by mbsoil_rx_frame and modbus_rtu_soil_read_transaction; depends on nothing.
package mbsoil_pkg;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_SLAVE   = 3'd2;
    localparam logic [2:0] ST_FUNC    = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;
    localparam logic [2:0] ST_LENGTH  = 3'd5;

    localparam int          FRAME_BYTES   = 21;
    localparam logic [4:0]  LAST_IDX      = 5'd20;
    localparam logic [4:0]  CRC_END_IDX   = 5'd19;
    localparam logic [7:0]  FUNC_READ     = 8'h03;
    localparam logic [7:0]  REG_COUNT     = 8'h08;
    localparam logic [7:0]  ZERO_BYTE     = 8'h00;
    localparam logic [7:0]  MIN_PAYLOAD   = 8'd16;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef struct packed {
        logic       start;
        logic       byte_en;
        logic       tick;
        logic [7:0] slave;
        logic [7:0] data;
    } rx_event_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic [15:0] conductivity;
        logic [15:0] ph;
    } outcome_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/mbsoil_rx_frame.sv
// Response collection, CRC tracking, timeout counting and frame checking.
// Depends on mbsoil_pkg.
module mbsoil_rx_frame (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mbsoil_pkg::rx_event_t  ev,
    input  logic [15:0]            timeout_ticks,
    output mbsoil_pkg::outcome_t   outcome
);
    import mbsoil_pkg::*;

    logic        receiving_reg, receiving_next;
    logic [7:0]  expected_slave_reg, expected_slave_next;
    logic [4:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  frame_reg [FRAME_BYTES];
    logic        store_we;
    logic [2:0]  check_status;
    logic [15:0] got_crc;

    assign got_crc = {ev.data, frame_reg[CRC_END_IDX]};

    always_comb
    begin
        if (frame_reg[0] != expected_slave_reg)
            check_status = ST_SLAVE;
        else if (frame_reg[1] != FUNC_READ)
            check_status = ST_FUNC;
        else if (got_crc != crc_reg)
            check_status = ST_CRC;
        else if (frame_reg[2] < MIN_PAYLOAD)
            check_status = ST_LENGTH;
        else
            check_status = ST_OK;
    end

    always_comb
    begin
        receiving_next      = receiving_reg;
        expected_slave_next = expected_slave_reg;
        count_next          = count_reg;
        crc_next            = crc_reg;
        elapsed_next        = elapsed_reg;
        store_we            = 1'b0;
        outcome             = '0;
        if (ev.start)
        begin
            receiving_next      = 1'b1;
            expected_slave_next = ev.slave;
            count_next          = 5'd0;
            crc_next            = CRC_SEED;
            elapsed_next        = 16'd0;
        end
        else if (receiving_reg)
        begin
            if (ev.byte_en)
            begin
                store_we   = 1'b1;
                count_next = count_reg + 5'd1;
                if (count_reg < CRC_END_IDX)
                    crc_next = crc_byte(crc_reg, ev.data);
                if (count_reg == LAST_IDX)
                begin
                    receiving_next = 1'b0;
                    outcome.valid  = 1'b1;
                    outcome.status = check_status;
                    if (check_status == ST_OK)
                    begin
                        outcome.temperature  = {frame_reg[3], frame_reg[4]};
                        outcome.humidity     = {frame_reg[5], frame_reg[6]};
                        outcome.conductivity = {frame_reg[7], frame_reg[8]};
                        outcome.ph           = {frame_reg[17], frame_reg[18]};
                    end
                end
            end
            else if (ev.tick)
            begin
                if (elapsed_reg != TICKS_MAX)
                    elapsed_next = elapsed_reg + 16'd1;
                if (elapsed_next >= timeout_ticks)
                begin
                    receiving_next = 1'b0;
                    outcome.valid  = 1'b1;
                    outcome.status = ST_TIMEOUT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg      <= 1'b0;
            expected_slave_reg <= 8'd0;
            count_reg          <= 5'd0;
            crc_reg            <= CRC_SEED;
            elapsed_reg        <= 16'd0;
        end
        else
        begin
            receiving_reg      <= receiving_next;
            expected_slave_reg <= expected_slave_next;
            count_reg          <= count_next;
            crc_reg            <= crc_next;
            elapsed_reg        <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            frame_reg[count_reg] <= ev.data;
    end

endmodule

### rtl/modbus_rtu_soil_read_transaction.sv
// Modbus RTU read-holding-registers master for a soil sensor: top level.
// A start item yields eight request bytes; a received byte or tick item may yield one outcome.
// An accepted item's first result is registered into the output register on the next clock.
// Byte and tick items are taken one per cycle while the output is not stalled; a start blocks
// the input while the request sequencer emits the other seven bytes.
// Reset is asynchronous and active low; it leaves the block idle with timeout_ticks at 1000.
module modbus_rtu_soil_read_transaction (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [7:0]         sensor_addr,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [7:0]         tx_byte,
    output logic               last,
    output logic [2:0]         status,
    output logic signed [15:0] temperature_tenths,
    output logic [15:0]        humidity_tenths,
    output logic [15:0]        conductivity,
    output logic [15:0]        ph_tenths
);
    import mbsoil_pkg::*;

    logic [15:0] timeout_reg;
    logic [2:0]  tx_idx_reg, tx_idx_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic [15:0] cond_reg, cond_next;
    logic [15:0] ph_reg, ph_next;
    logic        slot_free;
    logic        tx_busy;
    logic        accept;
    logic [7:0]  seq_byte;
    rx_event_t   ev;
    outcome_t    outcome;

    assign slot_free = !out_valid_reg || out_ready;
    assign tx_busy   = tx_idx_reg != 3'd0;
    assign in_ready  = slot_free && !tx_busy;
    assign accept    = in_valid && in_ready;

    assign ev.start   = accept && (req_type == REQ_START);
    assign ev.byte_en = accept && (req_type == REQ_BYTE);
    assign ev.tick    = accept && (req_type == REQ_TICK);
    assign ev.slave   = sensor_addr;
    assign ev.data    = rx_byte;

    mbsoil_rx_frame u_rx_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev            (ev),
        .timeout_ticks (timeout_reg),
        .outcome       (outcome)
    );

    always_comb
    begin
        case (tx_idx_reg)
            3'd1:    seq_byte = FUNC_READ;
            3'd2:    seq_byte = ZERO_BYTE;
            3'd3:    seq_byte = ZERO_BYTE;
            3'd4:    seq_byte = ZERO_BYTE;
            3'd5:    seq_byte = REG_COUNT;
            3'd6:    seq_byte = tx_crc_reg[7:0];
            3'd7:    seq_byte = tx_crc_reg[15:8];
            default: seq_byte = ZERO_BYTE;
        endcase
    end

    always_comb
    begin
        tx_idx_next    = tx_idx_reg;
        tx_crc_next    = tx_crc_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        temp_next      = temp_reg;
        hum_next       = hum_reg;
        cond_next      = cond_reg;
        ph_next        = ph_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (tx_busy)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = 1'b0;
                tx_byte_next   = seq_byte;
                last_next      = tx_idx_reg == 3'd7;
                status_next    = ST_OK;
                temp_next      = 16'd0;
                hum_next       = 16'd0;
                cond_next      = 16'd0;
                ph_next        = 16'd0;
                tx_idx_next    = tx_idx_reg + 3'd1;
                if (tx_idx_reg <= 3'd5)
                    tx_crc_next = crc_byte(tx_crc_reg, seq_byte);
            end
            else if (ev.start)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = 1'b0;
                tx_byte_next   = sensor_addr;
                last_next      = 1'b0;
                status_next    = ST_OK;
                temp_next      = 16'd0;
                hum_next       = 16'd0;
                cond_next      = 16'd0;
                ph_next        = 16'd0;
                tx_idx_next    = 3'd1;
                tx_crc_next    = crc_byte(CRC_SEED, sensor_addr);
            end
            else if (outcome.valid)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = 1'b1;
                tx_byte_next   = 8'd0;
                last_next      = 1'b0;
                status_next    = outcome.status;
                temp_next      = outcome.temperature;
                hum_next       = outcome.humidity;
                cond_next      = outcome.conductivity;
                ph_next        = outcome.ph;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            tx_idx_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
            tx_idx_reg    <= tx_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_crc_reg   <= tx_crc_next;
        out_kind_reg <= out_kind_next;
        tx_byte_reg  <= tx_byte_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        temp_reg     <= temp_next;
        hum_reg      <= hum_next;
        cond_reg     <= cond_next;
        ph_reg       <= ph_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_kind           = out_kind_reg;
    assign tx_byte            = tx_byte_reg;
    assign last               = last_reg;
    assign status             = status_reg;
    assign temperature_tenths = $signed(temp_reg);
    assign humidity_tenths    = hum_reg;
    assign conductivity       = cond_reg;
    assign ph_tenths          = ph_reg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the soil sensor Modbus RTU read master.
// It drives request, byte and tick items, predicts every request byte and outcome, and checks them.
// Depends on mbsoil_pkg and modbus_rtu_soil_read_transaction only.
module tb_top;
    import mbsoil_pkg::*;

    localparam logic [1:0] REQ_IGNORED   = 2'd3;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         STUCK_LIMIT   = 4000;

    typedef enum logic [1:0] { EV_ITEM, EV_CFG, EV_CALM, EV_END } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic [1:0]  req;
        logic [7:0]  slave;
        logic [7:0]  data;
        logic [15:0] cfg;
    } sensor_event_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic [2:0]  stat;
        logic [15:0] temp;
        logic [15:0] hum;
        logic [15:0] cond;
        logic [15:0] ph;
    } soil_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = REQ_TICK;
    logic [7:0]         sensor_addr = '0;
    logic [7:0]         rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               out_kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic [2:0]         status;
    logic signed [15:0] temperature_tenths;
    logic [15:0]        humidity_tenths;
    logic [15:0]        conductivity;
    logic [15:0]        ph_tenths;

    sensor_event_t sensor_events[$];
    soil_result_t  master_results[$];

    // Predicted state of the master.
    logic        rx_active = 1'b0;
    logic [7:0]  want_slave = '0;
    logic [4:0]  rx_count = '0;
    logic [15:0] crc_acc = CRC_SEED;
    logic [15:0] tick_count = '0;
    logic [15:0] timeout_now = TIMEOUT_RESET;
    logic [7:0]  frame_copy [FRAME_BYTES];

    int          items_queued = 0;
    int          plan_timeout = TIMEOUT_RESET;
    int          mismatches = 0;
    int          results_seen = 0;
    int          requests_seen = 0;
    int          cfg_writes = 0;
    int          outcome_tally [6] = '{0, 0, 0, 0, 0, 0};

    logic        accepted = 1'b0;
    logic        quiet = 1'b0;
    logic        stim_done = 1'b0;
    logic        calm = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          settle = 0;
    int unsigned stuck = 0;

    sensor_event_t head;
    soil_result_t  want;
    logic          nxt_valid;
    logic [1:0]    nxt_req;
    logic [7:0]    nxt_slave;
    logic [7:0]    nxt_data;
    logic          nxt_wr;
    logic [15:0]   nxt_wdata;
    logic          nxt_ready;

    modbus_rtu_soil_read_transaction dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .sensor_addr        (sensor_addr),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_kind           (out_kind),
        .tx_byte            (tx_byte),
        .last               (last),
        .status             (status),
        .temperature_tenths (temperature_tenths),
        .humidity_tenths    (humidity_tenths),
        .conductivity       (conductivity),
        .ph_tenths          (ph_tenths)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else if (r == 2)
            return 8'h80;
        return 8'($urandom);
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] wanted);
        $display("%0t ns: mismatch in %s at result %0d: got %h, expected %h",
                 $time, field, results_seen, got, wanted);
        mismatches++;
    endtask

    task automatic push_outcome(input logic [2:0] st);
        soil_result_t r;
        r = '0;
        r.kind = 1'b1;
        r.stat = st;
        if (st == ST_OK)
        begin
            r.temp = {frame_copy[3], frame_copy[4]};
            r.hum  = {frame_copy[5], frame_copy[6]};
            r.cond = {frame_copy[7], frame_copy[8]};
            r.ph   = {frame_copy[17], frame_copy[18]};
        end
        master_results.push_back(r);
        rx_active = 1'b0;
        outcome_tally[st]++;
    endtask

    task automatic predict_soil_master(input logic [1:0] kind, input logic [7:0] slv,
                                       input logic [7:0] dat);
        soil_result_t r;
        logic [7:0]   req [8];
        logic [15:0]  c;
        logic [2:0]   st;
        int           i;
        if (kind == REQ_START)
        begin
            req[0] = slv;
            req[1] = FUNC_READ;
            req[2] = ZERO_BYTE;
            req[3] = ZERO_BYTE;
            req[4] = ZERO_BYTE;
            req[5] = REG_COUNT;
            c = CRC_SEED;
            for (i = 0; i < 6; i++)
                c = crc16_update(c, req[i]);
            req[6] = c[7:0];
            req[7] = c[15:8];
            rx_active = 1'b1;
            want_slave = slv;
            rx_count = '0;
            crc_acc = CRC_SEED;
            tick_count = '0;
            for (i = 0; i < 8; i++)
            begin
                r = '0;
                r.tx = req[i];
                r.last = (i == 7);
                master_results.push_back(r);
            end
            requests_seen++;
        end
        else if (rx_active && kind == REQ_BYTE)
        begin
            frame_copy[rx_count] = dat;
            if (rx_count < CRC_END_IDX)
                crc_acc = crc16_update(crc_acc, dat);
            rx_count = rx_count + 5'd1;
            if (rx_count == FRAME_BYTES)
            begin
                if (frame_copy[0] != want_slave)
                    st = ST_SLAVE;
                else if (frame_copy[1] != FUNC_READ)
                    st = ST_FUNC;
                else if ({frame_copy[LAST_IDX], frame_copy[CRC_END_IDX]} != crc_acc)
                    st = ST_CRC;
                else if (frame_copy[2] < MIN_PAYLOAD)
                    st = ST_LENGTH;
                else
                    st = ST_OK;
                push_outcome(st);
            end
        end
        else if (rx_active && kind == REQ_TICK)
        begin
            if (tick_count != TICKS_MAX)
                tick_count = tick_count + 16'd1;
            if (tick_count >= timeout_now)
                push_outcome(ST_TIMEOUT);
        end
    endtask

    task automatic push_item(input logic [1:0] kind, input logic [7:0] slv, input logic [7:0] dat);
        sensor_event_t ev;
        ev.kind = EV_ITEM;
        ev.req = kind;
        ev.slave = slv;
        ev.data = dat;
        ev.cfg = '0;
        sensor_events.push_back(ev);
        items_queued++;
    endtask

    task automatic push_marker(input entry_kind_t kind, input logic [15:0] value);
        sensor_event_t ev;
        ev.kind = kind;
        ev.req = REQ_IGNORED;
        ev.slave = '0;
        ev.data = '0;
        ev.cfg = value;
        sensor_events.push_back(ev);
        if (kind == EV_CFG)
            plan_timeout = value;
    endtask

    // One read: a start, then a response that is whole, faulty or cut short.
    task automatic add_exchange();
        logic [7:0]  fr [FRAME_BYTES];
        logic [15:0] c;
        logic [7:0]  slv;
        int          flavour;
        int          cut;
        int          i;
        slv = pick_byte();
        push_item(REQ_START, slv, 8'($urandom));
        fr[0] = slv;
        fr[1] = FUNC_READ;
        fr[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(16, 255)) : MIN_PAYLOAD;
        for (i = 3; i < FRAME_BYTES; i++)
            fr[i] = pick_byte();
        flavour = $urandom_range(0, 19);
        cut = FRAME_BYTES;
        if (flavour == 11)
            fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
        else if (flavour == 12)
            fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
        else if (flavour == 13 || flavour == 19)
            fr[2] = 8'($urandom_range(0, 15));
        else if (flavour == 14)
        begin
            fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
            fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
        end
        else if (flavour == 15)
        begin
            fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
            fr[2] = 8'($urandom_range(0, 15));
        end
        else if (flavour == 16 || flavour == 17)
            cut = $urandom_range(0, FRAME_BYTES - 1);
        c = CRC_SEED;
        for (i = 0; i < FRAME_BYTES - 2; i++)
            c = crc16_update(c, fr[i]);
        fr[FRAME_BYTES - 2] = c[7:0];
        fr[FRAME_BYTES - 1] = c[15:8];
        if (flavour >= 18)
        begin
            i = FRAME_BYTES - 2 + $urandom_range(0, 1);
            fr[i] = fr[i] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_item(REQ_TICK, 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 29) == 0)
                push_item(REQ_IGNORED, 8'($urandom), 8'($urandom));
            push_item(REQ_BYTE, 8'($urandom), fr[i]);
        end
        if (cut < FRAME_BYTES && plan_timeout <= 40)
            repeat (plan_timeout + 1)
                push_item(REQ_TICK, 8'($urandom), 8'($urandom));
        else if (cut == FRAME_BYTES && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                push_item(REQ_BYTE, 8'($urandom), 8'($urandom));
    endtask

    task automatic fill_random(input int upto);
        while (items_queued < upto)
        begin
            if ($urandom_range(0, 5) == 0)
                push_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
            else
                add_exchange();
        end
    endtask

    initial
    begin
        // Idle noise, a start with one byte, then a restart in mid-reception.
        push_item(REQ_BYTE, 8'hFF, 8'h00);
        push_item(REQ_BYTE, 8'h00, 8'hFF);
        push_item(REQ_TICK, 8'hFF, 8'hFF);
        push_item(REQ_IGNORED, 8'hFF, 8'hFF);
        push_item(REQ_START, 8'hFF, 8'h00);
        push_item(REQ_BYTE, 8'h00, 8'hFF);
        push_item(REQ_IGNORED, 8'h00, 8'h00);
        push_item(REQ_TICK, 8'h00, 8'h00);
        push_item(REQ_START, 8'h00, 8'hFF);
        // A zero timeout fires on the first tick; later bytes are ignored.
        push_marker(EV_CFG, 16'd0);
        push_item(REQ_START, 8'h5A, 8'hA5);
        push_item(REQ_TICK, 8'hA5, 8'h5A);
        push_item(REQ_BYTE, 8'h5A, 8'hA5);
        push_marker(EV_CFG, 16'd1);
        push_item(REQ_START, 8'hA5, 8'h5A);
        push_item(REQ_BYTE, 8'hA5, 8'h5A);
        push_item(REQ_TICK, 8'h5A, 8'hA5);
        push_item(REQ_TICK, 8'h5A, 8'hA5);

        push_marker(EV_CFG, 16'hFFFF);
        fill_random(170);
        push_marker(EV_CFG, 16'($urandom_range(2, 30)));
        fill_random(340);
        push_marker(EV_CFG, TIMEOUT_RESET);
        push_marker(EV_CALM, '0);
        fill_random(480);
        push_marker(EV_END, '0);

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;

        while (!stim_done)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (master_results.size() != 0)
            report_mismatch("results never delivered", 16'(master_results.size()), 16'd0);

        $display("Run covered %0d request frames and %0d outcomes over %0d timeout settings.",
                 requests_seen, results_seen - 8 * requests_seen, cfg_writes);
        $display("Outcomes: ok %0d, timeout %0d, slave %0d, function %0d, crc %0d, length %0d.",
                 outcome_tally[ST_OK], outcome_tally[ST_TIMEOUT], outcome_tally[ST_SLAVE],
                 outcome_tally[ST_FUNC], outcome_tally[ST_CRC], outcome_tally[ST_LENGTH]);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            nxt_valid = in_valid && !accepted;
            nxt_req   = req_type;
            nxt_slave = sensor_addr;
            nxt_data  = rx_byte;
            nxt_wr    = 1'b0;
            nxt_wdata = cfg_wr_data;
            settle    = quiet ? settle + 1 : 0;
            if (!nxt_valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (sensor_events.size() != 0)
                begin
                    head = sensor_events[0];
                    case (head.kind)
                        EV_ITEM:
                            if (!calm && $urandom_range(0, 9) == 0)
                                gap_left = $urandom_range(0, 13);
                            else
                            begin
                                head = sensor_events.pop_front();
                                nxt_valid = 1'b1;
                                nxt_req   = head.req;
                                nxt_slave = head.slave;
                                nxt_data  = head.data;
                            end
                        EV_CFG:
                            if (settle >= SETTLE_CYCLES)
                            begin
                                head = sensor_events.pop_front();
                                nxt_wr = 1'b1;
                                nxt_wdata = head.cfg;
                                timeout_now = head.cfg;
                                settle = 0;
                                cfg_writes++;
                            end
                        EV_CALM:
                        begin
                            head = sensor_events.pop_front();
                            calm = 1'b1;
                        end
                        EV_END:
                            if (settle >= SETTLE_CYCLES)
                            begin
                                head = sensor_events.pop_front();
                                stim_done <= 1'b1;
                            end
                        default:
                            ;
                    endcase
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            in_valid    <= nxt_valid;
            req_type    <= nxt_req;
            sensor_addr <= nxt_slave;
            rx_byte     <= nxt_data;
            cfg_wr_en   <= nxt_wr;
            cfg_wr_data <= nxt_wdata;
            out_ready   <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (master_results.size() == 0)
                    report_mismatch("result with nothing expected", 16'(out_kind), 16'd0);
                else
                begin
                    want = master_results.pop_front();
                    if (out_kind !== want.kind)
                        report_mismatch("out_kind", 16'(out_kind), 16'(want.kind));
                    if (tx_byte !== want.tx)
                        report_mismatch("tx_byte", 16'(tx_byte), 16'(want.tx));
                    if (last !== want.last)
                        report_mismatch("last", 16'(last), 16'(want.last));
                    if (status !== want.stat)
                        report_mismatch("status", 16'(status), 16'(want.stat));
                    if (temperature_tenths !== want.temp)
                        report_mismatch("temperature_tenths", temperature_tenths, want.temp);
                    if (humidity_tenths !== want.hum)
                        report_mismatch("humidity_tenths", humidity_tenths, want.hum);
                    if (conductivity !== want.cond)
                        report_mismatch("conductivity", conductivity, want.cond);
                    if (ph_tenths !== want.ph)
                        report_mismatch("ph_tenths", ph_tenths, want.ph);
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                predict_soil_master(req_type, sensor_addr, rx_byte);
            accepted <= in_valid && in_ready;
            quiet    <= (!in_valid || in_ready) && master_results.size() == 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("Timed out after %0d cycles with no item moving.", stuck);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
